FILE: hdl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types, command codes and constants shared by the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int HP_WIDTH            = 16;
   localparam logic [HP_WIDTH-1:0] HALF_PERIOD_RESET = 16'd100;

   localparam int REQ_DATA_WIDTH = 16;
   localparam int REQ_USER_WIDTH = 2;
   localparam int RSP_DATA_WIDTH = 16;

   localparam logic [4:0] NSEG_START = 5'd2;
   localparam logic [4:0] NSEG_BYTE  = 5'd18;
   localparam logic [4:0] NSEG_STOP  = 5'd3;
   // first segment of the acknowledge slot
   localparam logic [4:0] SEG_ACK    = 5'd16;
   localparam logic [4:0] SEG_ACK_HI = 5'd17;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2,
      CMD_STOP  = 2'd3
   } cmd_type;

   // one tick as queued between front and back
   typedef struct packed {
      logic       cmd_valid;
      cmd_type    cmd;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_in;
   } item_type;

   typedef struct packed {
      logic       valid;
      item_type   item;
   } head_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       ack_received;
      logic       done_res;
      logic       busy_res;
      logic       sda_out;
      logic       scl_out;
   } rsp_type;

   function automatic logic [4:0] seg_total(input cmd_type cmd);
      logic [4:0] n;
      case (cmd)
         CMD_START: n = NSEG_START;
         CMD_STOP:  n = NSEG_STOP;
         default:   n = NSEG_BYTE;
      endcase
      return n;
   endfunction

endpackage

FILE: hdl/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts request beats, decodes the command and queues them (two entries).
// ----------------------------------------------------------------------------
module i2cm_front
   import i2cm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   input  logic [REQ_USER_WIDTH-1:0] req_tuser,
   input  logic                      pop,
   output head_type                  head
);

   item_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   item_type   item_dec;

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid & req_tready;

   always_comb begin
      item_dec.cmd_valid = req_tdata[0];
      item_dec.cmd       = cmd_type'(req_tuser[1:0]);
      item_dec.tx_byte   = req_tdata[8:1];
      item_dec.send_ack  = req_tdata[9];
      item_dec.sda_in    = req_tdata[10];
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item_dec;
      end
   end

   assign head.valid = (cnt_ff != 2'd0);
   assign head.item  = mem_ff[rd_ptr_ff];

endmodule

FILE: hdl/i2cm_engine.sv
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus sequencer: one queued tick per cycle unless the result is stalled, drives
// SCL/SDA segments and holds the result in an output register.
// ----------------------------------------------------------------------------
module i2cm_engine
   import i2cm_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic [HP_WIDTH-1:0]       half_period,
   input  head_type                  head,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   localparam int LW = ((COUNT_WIDTH > HP_WIDTH) ? COUNT_WIDTH : HP_WIDTH) + 1;
   localparam logic [LW-1:0] CAP = LW'(1) << COUNT_WIDTH;

   logic [4:0]             phase_ff, phase_in;
   cmd_type                cmd_ff, cmd_in;
   logic [COUNT_WIDTH-1:0] tick_ff, tick_in;
   logic [7:0]             shift_ff, shift_in;
   logic                   ackc_ff, ackc_in;
   logic                   ackf_ff, ackf_in;
   logic [7:0]             rx_ff, rx_in;
   logic                   scl_ff, scl_in;
   logic                   sda_ff, sda_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [LW-1:0] limit;
   logic [LW-1:0] next_cnt;
   logic          seg_end;
   logic [4:0]    seg;
   logic [4:0]    seg_apply;
   logic          apply;
   logic          done;
   item_type      it;

   assign it  = head.item;
   assign pop = head.valid & (~rsp_valid_ff | rsp_tready);

   // zero counts as one tick, and the segment saturates at the counter range
   always_comb begin
      limit = (half_period == '0) ? LW'(1) : LW'(half_period);
      if (limit > CAP) begin
         limit = CAP;
      end
      next_cnt = LW'(tick_ff) + LW'(1);
      seg_end  = (next_cnt >= limit);
      seg      = phase_ff - 5'd1;
   end

   always_comb begin
      phase_in  = phase_ff;
      cmd_in    = cmd_ff;
      tick_in   = tick_ff;
      shift_in  = shift_ff;
      ackc_in   = ackc_ff;
      ackf_in   = ackf_ff;
      rx_in     = rx_ff;
      scl_in    = scl_ff;
      sda_in    = sda_ff;
      done      = 1'b0;
      apply     = 1'b0;
      seg_apply = 5'd0;

      if (phase_ff == 5'd0) begin
         if (it.cmd_valid) begin
            cmd_in   = it.cmd;
            shift_in = (it.cmd == CMD_WRITE) ? it.tx_byte : 8'd0;
            ackc_in  = it.send_ack;
            tick_in  = '0;
            phase_in = 5'd1;
            apply    = 1'b1;
         end
      end else if (seg_end) begin
         // close the segment: shift data, sample the acknowledge
         if (cmd_ff == CMD_WRITE) begin
            if (seg < SEG_ACK && seg[0]) begin
               shift_in = {shift_ff[6:0], 1'b0};
            end
            if (seg == SEG_ACK_HI) begin
               ackf_in = ~it.sda_in;
            end
         end else if (cmd_ff == CMD_READ) begin
            if (seg < SEG_ACK && seg[0]) begin
               shift_in = {shift_ff[6:0], it.sda_in};
            end
         end
         tick_in = '0;
         if (seg + 5'd1 >= seg_total(cmd_ff)) begin
            case (cmd_ff)
               CMD_START: scl_in = 1'b0;
               CMD_WRITE: begin
                  scl_in = 1'b0;
                  sda_in = 1'b0;
               end
               CMD_READ: begin
                  rx_in  = shift_in;
                  scl_in = 1'b0;
                  sda_in = 1'b0;
               end
               default: ;
            endcase
            phase_in = 5'd0;
            done     = 1'b1;
         end else begin
            phase_in  = phase_ff + 5'd1;
            apply     = 1'b1;
            seg_apply = seg + 5'd1;
         end
      end else begin
         tick_in = tick_ff + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
      end

      if (apply) begin
         case (cmd_in)
            CMD_START: begin
               scl_in = 1'b1;
               sda_in = (seg_apply == 5'd0);
            end
            CMD_WRITE: begin
               scl_in = seg_apply[0];
               sda_in = (seg_apply < SEG_ACK) ? shift_in[7] : 1'b1;
            end
            CMD_READ: begin
               scl_in = seg_apply[0];
               sda_in = (seg_apply < SEG_ACK) ? 1'b1 : ~ackc_in;
            end
            default: begin
               if (seg_apply == 5'd1) begin
                  scl_in = 1'b1;
               end
               if (seg_apply == 5'd2) begin
                  sda_in = 1'b1;
               end
            end
         endcase
      end
   end

   always_comb begin
      rsp_in.scl_out      = scl_in;
      rsp_in.sda_out      = sda_in;
      rsp_in.busy_res     = (phase_in != 5'd0);
      rsp_in.done_res     = done;
      rsp_in.ack_received = ackf_in;
      rsp_in.rx_byte      = rx_in;
      rsp_valid_in        = pop | (rsp_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 5'd0;
         cmd_ff       <= CMD_START;
         tick_ff      <= '0;
         shift_ff     <= 8'd0;
         ackc_ff      <= 1'b0;
         ackf_ff      <= 1'b0;
         rx_ff        <= 8'd0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff <= phase_in;
            cmd_ff   <= cmd_in;
            tick_ff  <= tick_in;
            shift_ff <= shift_in;
            ackc_ff  <= ackc_in;
            ackf_ff  <= ackf_in;
            rx_ff    <= rx_in;
            scl_ff   <= scl_in;
            sda_ff   <= sda_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH-$bits(rsp_type)){1'b0}}, rsp_ff};

endmodule

FILE: hdl/i2c_master_byte_engine_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_unit
// Open-drain I2C master byte engine, one request beat per bus tick.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | req_tdata, req_tuser
//  rsp     | out | rsp_tvalid/rsp_tready | rsp_tdata
//  csr     | in  | csr_valid/csr_ready   | csr_data (half_period)
//
//  One beat per cycle in and out while rsp is not stalled; a beat's result reaches
//  rsp through the two-entry queue, then the sequencer's output register.
//  The sequencer steps once per beat, so bus timing counts beats, not cycles.
//  A stalled rsp holds its beat; the queue keeps taking beats until it is full.
//  Reset (synchronous) idles the bus with both lines released, half_period 100.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_unit
   import i2cm_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // [0] cmd_valid, [8:1] tx_byte, [9] send_ack, [10] sda_in
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   // [1:0] req_type
   input  logic [REQ_USER_WIDTH-1:0] req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [4] ack_received,
   // [12:5] rx_byte
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [HP_WIDTH-1:0]       csr_data
);

   logic [HP_WIDTH-1:0] hp_ff;
   head_type            head;
   logic                pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hp_ff <= HALF_PERIOD_RESET;
      end else if (csr_valid) begin
         hp_ff <= csr_data;
      end
   end

   i2cm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .pop        (pop),
      .head       (head)
   );

   i2cm_engine #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .half_period (hp_ff),
      .head        (head),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

FILE: hdl/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks on the I2C master byte engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cm_checker
   import i2cm_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   // a finishing beat has already left the busy state
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> !rsp_tdata[2])
      else $error("done beat still busy");

   // every command ends with SCL and SDA at the same level
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> rsp_tdata[0] == rsp_tdata[1])
      else $error("done beat with mismatched bus levels");

   // no result beat straight out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat after reset");

   // a stalled beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

endmodule

bind i2c_master_byte_engine_unit i2cm_checker u_i2cm_checker (.*);

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the I2C master byte engine. Every request beat is
// one bus tick; a cycle-true model of the bus sequencer predicts the line
// levels, busy, done, ack and received byte for each beat. The result stream
// is compared with those predictions in order. Directed tests cover the reset
// half period, byte extremes, ACK and NACK reads, commands while busy and a
// zero half period. Random transactions, mostly framed, run under random stalls on
// both channels, and a full start and stop at a longer half period ends it.
// ----------------------------------------------------------------------------
module tb;
   import i2cm_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   // [0] cmd_valid, [8:1] tx_byte, [9] send_ack, [10] sda_in
   logic [REQ_DATA_WIDTH-1:0] req_tdata  = '0;
   // [1:0] req_type
   logic [REQ_USER_WIDTH-1:0] req_tuser  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [4] ack_received,
   // [12:5] rx_byte
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [HP_WIDTH-1:0]       csr_data   = '0;

   // bus sequencer state as the bench sees it
   logic [HP_WIDTH-1:0] hp_reg;
   logic [4:0]          seg_phase;
   cmd_type             cur_cmd;
   logic [16:0]         tick_cnt;
   logic [7:0]          shreg;
   logic                ack_sel;
   logic                ack_seen;
   logic [7:0]          rx_hold;
   logic                scl_lv;
   logic                sda_lv;

   rsp_type expected_ticks[$];
   int      fail_count   = 0;
   int      beats_sent   = 0;
   int      rsp_beat     = 0;
   int      idle_cycles  = 0;
   int      stall_left   = 0;
   bit      quiet        = 1'b0;
   rsp_type exp_r;
   rsp_type got_r;

   i2c_master_byte_engine_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------ model
   function automatic void set_lines(input logic [4:0] seg);
      case (cur_cmd)
         CMD_START: begin
            scl_lv = 1'b1;
            sda_lv = (seg == 5'd0);
         end
         CMD_WRITE: begin
            scl_lv = seg[0];
            sda_lv = (seg < SEG_ACK) ? shreg[7] : 1'b1;
         end
         CMD_READ: begin
            scl_lv = seg[0];
            sda_lv = (seg < SEG_ACK) ? 1'b1 : ~ack_sel;
         end
         default: begin
            // stop: release SCL, then SDA
            if (seg == 5'd1) scl_lv = 1'b1;
            if (seg == 5'd2) sda_lv = 1'b1;
         end
      endcase
   endfunction

   function automatic void close_segment(input logic [4:0] seg, input logic sda);
      if (cur_cmd == CMD_WRITE) begin
         if (seg < SEG_ACK && seg[0]) shreg = {shreg[6:0], 1'b0};
         if (seg == SEG_ACK_HI) ack_seen = ~sda;
      end else if (cur_cmd == CMD_READ) begin
         if (seg < SEG_ACK && seg[0]) shreg = {shreg[6:0], sda};
      end
   endfunction

   function automatic rsp_type engine_tick(input item_type it);
      logic [16:0] lim;
      logic [16:0] nxt;
      logic [4:0]  seg;
      logic [4:0]  last_seg;
      logic        done;
      rsp_type     r;
      done = 1'b0;
      lim  = (hp_reg == '0) ? 17'd1 : {1'b0, hp_reg};
      if (seg_phase == 5'd0) begin
         if (it.cmd_valid) begin
            cur_cmd   = it.cmd;
            shreg     = (it.cmd == CMD_WRITE) ? it.tx_byte : 8'd0;
            ack_sel   = it.send_ack;
            tick_cnt  = '0;
            seg_phase = 5'd1;
            set_lines(5'd0);
         end
      end else begin
         nxt = tick_cnt + 17'd1;
         if (nxt >= lim) begin
            seg      = seg_phase - 5'd1;
            last_seg = (cur_cmd == CMD_START) ? NSEG_START :
                       (cur_cmd == CMD_STOP)  ? NSEG_STOP  : NSEG_BYTE;
            close_segment(seg, it.sda_in);
            tick_cnt = '0;
            if (seg + 5'd1 >= last_seg) begin
               if (cur_cmd == CMD_START) begin
                  scl_lv = 1'b0;
               end else if (cur_cmd != CMD_STOP) begin
                  if (cur_cmd == CMD_READ) rx_hold = shreg;
                  scl_lv = 1'b0;
                  sda_lv = 1'b0;
               end
               seg_phase = 5'd0;
               done      = 1'b1;
            end else begin
               seg_phase = seg + 5'd2;
               set_lines(seg + 5'd1);
            end
         end else begin
            tick_cnt = nxt;
         end
      end
      r.scl_out      = scl_lv;
      r.sda_out      = sda_lv;
      r.busy_res     = (seg_phase != 5'd0);
      r.done_res     = done;
      r.ack_received = ack_seen;
      r.rx_byte      = rx_hold;
      return r;
   endfunction

   // ------------------------------------------------------------- drivers
   task automatic send_tick(input item_type it);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, it.sda_in, it.send_ack, it.tx_byte, it.cmd_valid};
      req_tuser  <= it.cmd;
      do @(posedge clock); while (!req_tready);
      expected_ticks.push_back(engine_tick(it));
      beats_sent++;
      if (!quiet && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 14);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // issue one command while idle, then tick until the sequencer is idle again;
   // busy ticks carry random commands that must be ignored
   task automatic run_cmd(input cmd_type c, input logic [7:0] b, input logic a);
      item_type it;
      it.cmd_valid = 1'b1;
      it.cmd       = c;
      it.tx_byte   = b;
      it.send_ack  = a;
      it.sda_in    = 1'($urandom_range(0, 1));
      send_tick(it);
      while (seg_phase != 5'd0) begin
         it.cmd_valid = ($urandom_range(0, 3) == 0);
         it.cmd       = cmd_type'(2'($urandom_range(0, 3)));
         it.tx_byte   = 8'($urandom_range(0, 255));
         it.send_ack  = 1'($urandom_range(0, 1));
         it.sda_in    = 1'($urandom_range(0, 1));
         send_tick(it);
      end
   endtask

   task automatic idle_ticks(input int n);
      item_type it;
      repeat (n) begin
         it.cmd_valid = 1'b0;
         it.cmd       = cmd_type'(2'($urandom_range(0, 3)));
         it.tx_byte   = 8'($urandom_range(0, 255));
         it.send_ack  = 1'($urandom_range(0, 1));
         it.sda_in    = 1'($urandom_range(0, 1));
         send_tick(it);
      end
   endtask

   // drain every outstanding beat, then let the pipeline go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_ticks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_half_period(input logic [HP_WIDTH-1:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      hp_reg = v;
   endtask

   task automatic random_transaction();
      int n;
      if ($urandom_range(0, 4) == 0) begin
         run_cmd(cmd_type'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
      end else begin
         run_cmd(CMD_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         run_cmd(CMD_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1))
               run_cmd(CMD_READ, 8'($urandom_range(0, 255)),
                       (i < n - 1) ? 1'b1 : ($urandom_range(0, 3) == 0));
            else
               run_cmd(CMD_WRITE, 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
         end
         run_cmd(CMD_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      idle_ticks($urandom_range(0, 3));
   endtask

   // ------------------------------------------------------------- tests
   task automatic test_reset_half_period();
      run_cmd(CMD_START, 8'h00, 1'b0);
      settle();
   endtask

   task automatic test_byte_edges();
      write_half_period(16'd1);
      run_cmd(CMD_START, 8'hFF, 1'b1);
      run_cmd(CMD_WRITE, 8'h00, 1'b0);
      run_cmd(CMD_WRITE, 8'hFF, 1'b1);
      run_cmd(CMD_WRITE, 8'hA5, 1'b0);
      run_cmd(CMD_READ, 8'h00, 1'b1);
      run_cmd(CMD_READ, 8'hFF, 1'b0);
      run_cmd(CMD_STOP, 8'h00, 1'b0);
      // stray commands outside any frame
      run_cmd(CMD_STOP, 8'h5A, 1'b1);
      run_cmd(CMD_WRITE, 8'h3C, 1'b1);
      run_cmd(CMD_READ, 8'hC3, 1'b1);
      settle();
   endtask

   task automatic test_zero_half_period();
      write_half_period(16'd0);
      run_cmd(CMD_START, 8'h00, 1'b0);
      run_cmd(CMD_WRITE, 8'h5A, 1'b0);
      run_cmd(CMD_READ, 8'h00, 1'b1);
      run_cmd(CMD_STOP, 8'h00, 1'b0);
      settle();
   endtask

   task automatic test_random_traffic();
      logic [HP_WIDTH-1:0] hps[5] = '{16'd2, 16'd1, 16'd3, 16'd1, 16'd4};
      int                  mark;
      foreach (hps[k]) begin
         write_half_period(hps[k]);
         mark = beats_sent;
         while (beats_sent - mark < 150) random_transaction();
         settle();
      end
   endtask

   task automatic test_long_half_period();
      quiet = 1'b1;
      write_half_period(16'd20);
      run_cmd(CMD_START, 8'h00, 1'b0);
      run_cmd(CMD_STOP, 8'h00, 1'b0);
      settle();
   endtask

   // ------------------------------------------------------------- checking
   task automatic check_field(input string nm, input logic [7:0] e,
                              input logic [7:0] a);
      if (a !== e) begin
         fail_count++;
         if (fail_count <= 10)
            $display("beat %0d %s: expected %0h, got %0h", rsp_beat, nm, e, a);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_ticks.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("beat %0d: unexpected result %0h", rsp_beat, rsp_tdata);
         end else begin
            exp_r = expected_ticks.pop_front();
            got_r = rsp_type'(rsp_tdata[12:0]);
            check_field("scl_out", {7'd0, exp_r.scl_out}, {7'd0, got_r.scl_out});
            check_field("sda_out", {7'd0, exp_r.sda_out}, {7'd0, got_r.sda_out});
            check_field("busy_res", {7'd0, exp_r.busy_res}, {7'd0, got_r.busy_res});
            check_field("done_res", {7'd0, exp_r.done_res}, {7'd0, got_r.done_res});
            check_field("ack_received", {7'd0, exp_r.ack_received},
                        {7'd0, got_r.ack_received});
            check_field("rx_byte", exp_r.rx_byte, got_r.rx_byte);
         end
         rsp_beat++;
      end
   end

   // result-side back-pressure in bursts
   always @(posedge clock) begin
      if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[i2c_master_byte_engine_unit] ERROR");
            $finish;
         end
      end
   end

   initial begin
      hp_reg    = HALF_PERIOD_RESET;
      seg_phase = 5'd0;
      cur_cmd   = CMD_START;
      tick_cnt  = '0;
      shreg     = 8'd0;
      ack_sel   = 1'b0;
      ack_seen  = 1'b0;
      rx_hold   = 8'd0;
      scl_lv    = 1'b1;
      sda_lv    = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_half_period();
      test_byte_edges();
      test_zero_half_period();
      test_random_traffic();
      test_long_half_period();

      repeat (8) @(posedge clock);
      if (fail_count == 0 && expected_ticks.size() == 0)
         $display("[i2c_master_byte_engine_unit] OK");
      else
         $display("[i2c_master_byte_engine_unit] ERROR");
      $finish;
   end

endmodule
